FILE: rtl/soi_pkg.sv
// soi_pkg: shared widths, request and status codes for the sparse offset index
// no dependencies; used by sparse_offset_index
package soi_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned KEY_W        = 64;
  localparam int unsigned POS_W        = 64;
  localparam int unsigned COUNT_W      = 11;
  localparam int unsigned STATUS_W     = 2;

  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_APPENDED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

endpackage

FILE: rtl/soi_mem.sv
// soi_mem: simple dual-port synchronous ram, one write and one registered read
// depends on nothing; instantiated for the key and position stores
module soi_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/sparse_offset_index.sv
// sparse_offset_index: ordered (key, position) table with floor lookup
// depends on soi_pkg and soi_mem (key store and position store)
//
// The block holds up to CAPACITY (key, position) pairs in two synchronous rams.
// An append transaction (req_type 0) writes the pair into the next free slot
// and answers appended, or table full once CAPACITY entries are held. A lookup
// transaction (req_type 1) binary-searches the held entries for the last one
// whose key is not greater than the requested key and answers found with its
// position, or not found (position zero). Every result carries the entry count
// after the request. Keys are expected in nondecreasing order; out-of-order
// keys are stored as given and the search runs unchanged over them. One
// transaction is worked on at a time. An append passes through the done state
// and back to idle before the next accept. A lookup runs one halving step per
// cycle, each step being one key-ram read and compare, so floor(log2(count))+1
// steps at most; the position ram is then read, the result loaded and handed
// to the output register once it is free, and the block returns to ready.
// The result sits in an output register, so a new transaction is accepted
// while the previous result still waits to be taken. Stores need no reset:
// only slots below the entry count are ever read.
module sparse_offset_index #(
  parameter int unsigned CAPACITY = soi_pkg::CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // request channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_req_type,
  input  logic [soi_pkg::KEY_W-1:0]    in_key,
  input  logic [soi_pkg::POS_W-1:0]    in_position,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [soi_pkg::STATUS_W-1:0] out_status,
  output logic [soi_pkg::POS_W-1:0]    out_found_position,
  output logic [soi_pkg::COUNT_W-1:0]  out_count
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned OW = soi_pkg::COUNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_POS,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // search window: lo is the first candidate, n the number of candidates left
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic [soi_pkg::KEY_W-1:0] key_r, key_nxt;

  // pending result, and the output register that faces the consumer
  soi_pkg::status_t          res_status_r, res_status_nxt;
  logic [soi_pkg::POS_W-1:0] res_pos_r, res_pos_nxt;
  logic                      out_valid_r, out_valid_nxt;
  soi_pkg::status_t          out_status_r, out_status_nxt;
  logic [soi_pkg::POS_W-1:0] out_pos_r, out_pos_nxt;
  logic [OW-1:0]             out_count_r, out_count_nxt;

  // memory ports
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [AW-1:0]             key_raddr;
  logic [AW-1:0]             pos_raddr;
  logic [soi_pkg::KEY_W-1:0] key_rdata;
  logic [soi_pkg::POS_W-1:0] pos_rdata;

  // per-step search arithmetic
  logic [CW-1:0] half;
  logic [CW-1:0] lo_step;
  logic [CW-1:0] n_step;
  logic [CW-1:0] mid_step;
  logic [CW-1:0] pos_idx;
  logic [CW-1:0] mid_first;
  logic [CW+OW-1:0] count_ext;

  logic in_accept;
  logic out_free;
  logic full;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign full      = (count_r == CW'(CAPACITY));

  // the next free slot; only written while the table is not full
  assign mem_waddr = count_r[AW-1:0];

  // low bits of the count after this request, zero-extended where narrower
  assign count_ext = {{OW{1'b0}}, count_nxt};

  assign half      = n_r >> 1;
  assign mid_first = count_r >> 1;

  // one halving step: go left when the probed key is greater, else go right
  always_comb begin
    if (key_r < key_rdata) begin
      lo_step = lo_r;
      n_step  = half;
    end else begin
      lo_step = mid_r + CW'(1);
      n_step  = n_r - half - CW'(1);
    end
    mid_step = lo_step + (n_step >> 1);
    pos_idx  = lo_step - CW'(1);
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    lo_nxt         = lo_r;
    n_nxt          = n_r;
    mid_nxt        = mid_r;
    key_nxt        = key_r;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_count_nxt  = out_count_r;
    mem_we         = 1'b0;
    key_raddr      = mid_r[AW-1:0];
    pos_raddr      = pos_idx[AW-1:0];

    // consumer took the result
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          res_pos_nxt = '0;
          if (in_req_type == soi_pkg::REQ_APPEND) begin
            if (full) begin
              res_status_nxt = soi_pkg::ST_FULL;
            end else begin
              mem_we         = 1'b1;
              count_nxt      = count_r + CW'(1);
              res_status_nxt = soi_pkg::ST_APPENDED;
            end
            state_nxt = S_DONE;
          end else begin
            key_nxt = in_key;
            if (count_r == '0) begin
              // empty table
              res_status_nxt = soi_pkg::ST_NOT_FOUND;
              state_nxt      = S_DONE;
            end else begin
              // first probe sits in the middle of the whole table
              lo_nxt    = '0;
              n_nxt     = count_r;
              mid_nxt   = mid_first;
              key_raddr = mid_first[AW-1:0];
              state_nxt = S_CMP;
            end
          end
        end
      end

      S_CMP: begin
        // key_rdata holds key_store[mid_r]; next probe issued in the same cycle
        lo_nxt    = lo_step;
        n_nxt     = n_step;
        mid_nxt   = mid_step;
        key_raddr = mid_step[AW-1:0];
        if (n_step == '0) begin
          if (lo_step == '0) begin
            // every key is greater
            res_status_nxt = soi_pkg::ST_NOT_FOUND;
            state_nxt      = S_DONE;
          end else begin
            pos_raddr = pos_idx[AW-1:0];
            state_nxt = S_POS;
          end
        end
      end

      S_POS: begin
        res_status_nxt = soi_pkg::ST_FOUND;
        res_pos_nxt    = pos_rdata;
        state_nxt      = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_pos_nxt    = res_pos_r;
          out_count_nxt  = count_ext[OW-1:0];
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r         <= lo_nxt;
    n_r          <= n_nxt;
    mid_r        <= mid_nxt;
    key_r        <= key_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_count_r  <= out_count_nxt;
  end

  // key store: probed once per halving step
  soi_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (soi_pkg::KEY_W)
  ) u_key_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (in_key),
    .rd_addr (key_raddr),
    .rd_data (key_rdata)
  );

  // position store: read once at the end of a successful search
  soi_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (soi_pkg::POS_W)
  ) u_pos_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (in_position),
    .rd_addr (pos_raddr),
    .rd_data (pos_rdata)
  );

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_pos_r;
  assign out_count          = out_count_r;

endmodule
